@@ hdl/sdspi_pkg.sv @@
// Shared types and constants for the SD SPI command/response engine.
`default_nettype none

package sdspi_pkg;

	localparam int unsigned MAX_RESPONSE_BYTES = 8;

	localparam logic [7:0] CMD_START_BITS = 8'h40;
	localparam logic [7:0] CRC_CMD0       = 8'h95;
	localparam logic [7:0] CRC_CMD8       = 8'h87;
	localparam logic [7:0] CRC_DEFAULT    = 8'h01;
	localparam logic [7:0] FILL_BYTE      = 8'hFF;
	localparam logic [7:0] CMD_LIMIT      = 8'd64;
	localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
	localparam logic [5:0] CMD_SEND_IF    = 6'd8;
	localparam logic [8:0] POLL_LIMIT_RST = 9'd256;

	// Register indexes
	localparam logic REG_POLL_LIMIT = 1'b0;

	// Input operations
	localparam logic OP_START = 1'b0;
	localparam logic OP_RX    = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_RESP = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ILLEGAL = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;
	localparam logic [1:0] ST_RESPERR = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_value;
		logic [2:0] byte_index;
		logic [1:0] status;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

@@ hdl/sd_spi_command_response_engine.sv @@
// Top level of the SD SPI command/response engine.
`default_nettype none

// SD SPI command/response engine. Each input transaction is one SPI byte
// exchange: a start (op 0) latches the command index, argument and response
// length and returns the first command byte; each received byte (op 1) steps
// the command send, the 0xFF polling, the response read and the clearing byte,
// and the final item returns a done result with the status. An item yields
// zero, one or two results; they are computed in the accept cycle and land in
// a two-entry result buffer that drives the output port. A new item is taken
// whenever the buffer will be empty after the current output transaction, so
// one-result items flow one per cycle while out_stall is low, and two-result
// items (response bytes, the first non-0xFF poll byte) admit the next item as
// their second result leaves. poll_limit (APB, byte address 0) is 9 bits,
// resets to 256, and a value of 0 acts as 1. prdata returns the register.
module sd_spi_command_response_engine
	import sdspi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [7:0]  cmd_index,
	input  wire logic [31:0] argument,
	input  wire logic [3:0]  response_length,
	input  wire logic [7:0]  rx_byte,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [1:0]  kind,
	output logic      [7:0]  byte_value,
	output logic      [2:0]  byte_index,
	output logic      [1:0]  status,
	output logic             last
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CMD,
		PH_POLL,
		PH_READ,
		PH_CLEAR
	} phase_t;

	localparam logic [3:0] MAX_LEN = 4'(MAX_RESPONSE_BYTES);

	phase_t      phase_q, phase_d;
	logic [2:0]  byte_cnt_q, byte_cnt_d;
	logic [8:0]  poll_cnt_q, poll_cnt_d;
	logic [5:0]  cmd_q, cmd_d;
	logic [31:0] arg_q, arg_d;
	logic [3:0]  len_q, len_d;
	logic [1:0]  status_q, status_d;
	logic [8:0]  poll_limit_q;

	result_t     slot0_q, slot1_q;
	logic [1:0]  cnt_q;

	result_t     res0, res1;
	logic [1:0]  nres;
	logic        pop, accept, cfg_wr;
	logic [8:0]  lim;
	logic [3:0]  len_sat;
	logic [7:0]  arg_byte, crc_byte;

	// APB: always ready, one register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_POLL_LIMIT) ? {23'd0, poll_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= POLL_LIMIT_RST;
		end else if (cfg_wr && paddr[2] == REG_POLL_LIMIT) begin
			poll_limit_q <= pwdata[8:0];
		end
	end

	// Output side: head slot drives the port
	assign out_valid  = (cnt_q != 2'd0);
	assign kind       = slot0_q.kind;
	assign byte_value = slot0_q.byte_value;
	assign byte_index = slot0_q.byte_index;
	assign status     = slot0_q.status;
	assign last       = slot0_q.last;
	assign pop        = out_valid & ~out_stall;

	// Take a new item only if the buffer drains empty this cycle
	assign in_stall = ~((cnt_q == 2'd0) || (cnt_q == 2'd1 && pop));
	assign accept   = in_valid & ~in_stall;

	assign lim = (poll_limit_q == 9'd0) ? 9'd1 : poll_limit_q;

	always_comb begin
		if (response_length == 4'd0)
			len_sat = 4'd1;
		else if (response_length > MAX_LEN)
			len_sat = MAX_LEN;
		else
			len_sat = response_length;
	end

	always_comb begin
		case (byte_cnt_q)
			3'd1:    arg_byte = arg_q[31:24];
			3'd2:    arg_byte = arg_q[23:16];
			3'd3:    arg_byte = arg_q[15:8];
			3'd4:    arg_byte = arg_q[7:0];
			default: arg_byte = 8'd0;
		endcase
	end

	always_comb begin
		if (cmd_q == CMD_GO_IDLE)
			crc_byte = CRC_CMD0;
		else if (cmd_q == CMD_SEND_IF)
			crc_byte = CRC_CMD8;
		else
			crc_byte = CRC_DEFAULT;
	end

	// Per-item step: next state and up to two results
	always_comb begin
		phase_d    = phase_q;
		byte_cnt_d = byte_cnt_q;
		poll_cnt_d = poll_cnt_q;
		cmd_d      = cmd_q;
		arg_d      = arg_q;
		len_d      = len_q;
		status_d   = status_q;
		res0       = '{kind: KIND_TX, byte_value: FILL_BYTE, byte_index: 3'd0,
			status: ST_OK, last: 1'b0};
		res1       = res0;
		nres       = 2'd0;
		if (op == OP_START) begin
			nres = 2'd1;
			if (cmd_index >= CMD_LIMIT) begin
				phase_d = PH_IDLE;
				res0.kind       = KIND_DONE;
				res0.byte_value = 8'd0;
				res0.status     = ST_ILLEGAL;
			end else begin
				cmd_d      = cmd_index[5:0];
				arg_d      = argument;
				len_d      = len_sat;
				status_d   = ST_OK;
				poll_cnt_d = 9'd0;
				byte_cnt_d = 3'd1;
				phase_d    = PH_CMD;
				res0.byte_value = CMD_START_BITS | {2'b00, cmd_index[5:0]};
			end
		end else begin
			case (phase_q)
				PH_CMD: begin
					nres = 2'd1;
					if (byte_cnt_q >= 3'd1 && byte_cnt_q <= 3'd4) begin
						res0.byte_value = arg_byte;
						byte_cnt_d      = byte_cnt_q + 3'd1;
					end else if (byte_cnt_q == 3'd5) begin
						res0.byte_value = crc_byte;
						byte_cnt_d      = 3'd6;
					end else begin
						poll_cnt_d = 9'd1;
						phase_d    = PH_POLL;
					end
				end
				PH_POLL: begin
					if (rx_byte == FILL_BYTE) begin
						nres = 2'd1;
						if (poll_cnt_q >= lim) begin
							status_d = ST_TIMEOUT;
							phase_d  = PH_CLEAR;
						end else begin
							poll_cnt_d = poll_cnt_q + 9'd1;
						end
					end else begin
						nres = 2'd2;
						res0.kind       = KIND_RESP;
						res0.byte_value = rx_byte;
						if (rx_byte == 8'h00 || rx_byte == 8'h01) begin
							status_d = ST_OK;
							if (len_q > 4'd1) begin
								byte_cnt_d = 3'd1;
								phase_d    = PH_READ;
							end else begin
								phase_d = PH_CLEAR;
							end
						end else begin
							status_d = ST_RESPERR;
							phase_d  = PH_CLEAR;
						end
					end
				end
				PH_READ: begin
					nres = 2'd2;
					res0.kind       = KIND_RESP;
					res0.byte_value = rx_byte;
					res0.byte_index = byte_cnt_q;
					if ({1'b0, byte_cnt_q} + 4'd1 >= len_q)
						phase_d = PH_CLEAR;
					else
						byte_cnt_d = byte_cnt_q + 3'd1;
				end
				PH_CLEAR: begin
					nres = 2'd1;
					res0.kind       = KIND_DONE;
					res0.byte_value = 8'd0;
					res0.status     = status_q;
					phase_d         = PH_IDLE;
				end
				default: begin
					// idle: drop received bytes
					phase_d = PH_IDLE;
				end
			endcase
		end
		// mark the final result of this item
		if (nres == 2'd1)
			res0.last = 1'b1;
		if (nres == 2'd2)
			res1.last = 1'b1;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			byte_cnt_q <= 3'd0;
			poll_cnt_q <= 9'd0;
			cmd_q      <= 6'd0;
			arg_q      <= 32'd0;
			len_q      <= 4'd0;
			status_q   <= ST_OK;
			cnt_q      <= 2'd0;
		end else begin
			if (accept) begin
				phase_q    <= phase_d;
				byte_cnt_q <= byte_cnt_d;
				poll_cnt_q <= poll_cnt_d;
				cmd_q      <= cmd_d;
				arg_q      <= arg_d;
				len_q      <= len_d;
				status_q   <= status_d;
				cnt_q      <= nres;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Result buffer payload: load on accept, else advance on pop
	always_ff @(posedge clk) begin
		if (accept) begin
			slot0_q <= res0;
			slot1_q <= res1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

`default_nettype wire
